### sv/abqr_pkg.sv
// shared types and constants for the analog button qualifier with auto repeat
// no dependencies, used by every module of the block
package abqr_pkg;

    localparam int VALUE_FRAC_BITS_DEF = 12;
    localparam int TIME_BITS_DEF       = 32;
    localparam int DELTA_W             = 16;
    localparam int DELAY_W             = 24;
    localparam int RC_W                = 26;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 24;

    // register reset values; thresholds and dead zone bounds given in Q0.12
    localparam int RST_FRAC            = 12;
    localparam int RST_PRESS_THR_Q12   = 2048;
    localparam int RST_DEAD_LOW_Q12    = 819;
    localparam int RST_DEAD_HIGH_Q12   = 3686;
    localparam logic RST_NORMALIZE_ON  = 1'b1;
    localparam logic RST_SQUARE_ON     = 1'b0;
    localparam logic RST_REPEAT_ON     = 1'b0;
    localparam logic [DELAY_W-1:0] RST_FIRST_DELAY  = 24'd400000;
    localparam logic [DELAY_W-1:0] RST_REPEAT_PER   = 24'd80000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_THRESHOLD  = 3'd0,
        CFG_DEAD_LOW         = 3'd1,
        CFG_DEAD_HIGH        = 3'd2,
        CFG_NORMALIZE_ON     = 3'd3,
        CFG_SQUARE_CURVE_ON  = 3'd4,
        CFG_REPEAT_ON        = 3'd5,
        CFG_FIRST_DELAY_US   = 3'd6,
        CFG_REPEAT_PERIOD_US = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQ,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic square;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_status;

endpackage

### sv/abqr_ctrl.sv
// sequencing state machine: load, divide, square, write result
// depends on abqr_pkg for state, command and status types
module abqr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  abqr_pkg::t_status  i_status,
    output abqr_pkg::t_cmd     o_cmd,
    output logic               o_in_stall
);

    abqr_pkg::t_state r_state;
    abqr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abqr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            abqr_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = abqr_pkg::ST_DIV;
                end
            end
            abqr_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = abqr_pkg::ST_SQ;
                end
            end
            abqr_pkg::ST_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = abqr_pkg::ST_FIN;
            end
            abqr_pkg::ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = abqr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = abqr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/abqr_datapath.sv
// config registers, level shaping with iterative divider and squarer,
// press and repeat state, time counters and output register; uses abqr_pkg
module abqr_datapath #(
    parameter int VALUE_FRAC_BITS = abqr_pkg::VALUE_FRAC_BITS_DEF,
    parameter int TIME_BITS       = abqr_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [abqr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [abqr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [VALUE_FRAC_BITS:0]          i_sample,
    input  logic [abqr_pkg::DELTA_W-1:0]      i_delta_time,
    input  logic                              i_out_stall,
    input  abqr_pkg::t_cmd                    i_cmd,
    output abqr_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    output logic                              o_pressed,
    output logic                              o_press_edge,
    output logic                              o_release_edge,
    output logic [VALUE_FRAC_BITS:0]          o_level,
    output logic [TIME_BITS-1:0]              o_hold_time,
    output logic [TIME_BITS-1:0]              o_since_press,
    output logic [TIME_BITS-1:0]              o_since_release
);

    localparam int LW    = VALUE_FRAC_BITS + 1;
    localparam int CNT_W = $clog2(VALUE_FRAC_BITS);
    localparam int DW    = abqr_pkg::DELTA_W;
    localparam int RW    = abqr_pkg::RC_W;
    localparam logic [LW-1:0] ONE_VAL = LW'(1) << VALUE_FRAC_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [LW-1:0] RST_THR =
        LW'((abqr_pkg::RST_PRESS_THR_Q12 << VALUE_FRAC_BITS) >> abqr_pkg::RST_FRAC);
    localparam logic [LW-1:0] RST_DLOW =
        LW'((abqr_pkg::RST_DEAD_LOW_Q12 << VALUE_FRAC_BITS) >> abqr_pkg::RST_FRAC);
    localparam logic [LW-1:0] RST_DHIGH =
        LW'((abqr_pkg::RST_DEAD_HIGH_Q12 << VALUE_FRAC_BITS) >> abqr_pkg::RST_FRAC);

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                      input logic [DW-1:0] b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + (TIME_BITS+1)'(b);
        return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    endfunction

    // config registers
    logic [LW-1:0]                     r_thr;
    logic [LW-1:0]                     r_dlow;
    logic [LW-1:0]                     r_dhigh;
    logic                              r_norm_on;
    logic                              r_square_on;
    logic                              r_repeat_on;
    logic [abqr_pkg::DELAY_W-1:0]      r_first_delay;
    logic [abqr_pkg::DELAY_W-1:0]      r_repeat_per;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr         <= RST_THR;
            r_dlow        <= RST_DLOW;
            r_dhigh       <= RST_DHIGH;
            r_norm_on     <= abqr_pkg::RST_NORMALIZE_ON;
            r_square_on   <= abqr_pkg::RST_SQUARE_ON;
            r_repeat_on   <= abqr_pkg::RST_REPEAT_ON;
            r_first_delay <= abqr_pkg::RST_FIRST_DELAY;
            r_repeat_per  <= abqr_pkg::RST_REPEAT_PER;
        end else if (i_cfg_valid) begin
            case (abqr_pkg::t_cfg_idx'(i_cfg_index))
                abqr_pkg::CFG_PRESS_THRESHOLD:  r_thr         <= i_cfg_data[LW-1:0];
                abqr_pkg::CFG_DEAD_LOW:         r_dlow        <= i_cfg_data[LW-1:0];
                abqr_pkg::CFG_DEAD_HIGH:        r_dhigh       <= i_cfg_data[LW-1:0];
                abqr_pkg::CFG_NORMALIZE_ON:     r_norm_on     <= i_cfg_data[0];
                abqr_pkg::CFG_SQUARE_CURVE_ON:  r_square_on   <= i_cfg_data[0];
                abqr_pkg::CFG_REPEAT_ON:        r_repeat_on   <= i_cfg_data[0];
                abqr_pkg::CFG_FIRST_DELAY_US:   r_first_delay <= i_cfg_data;
                abqr_pkg::CFG_REPEAT_PERIOD_US: r_repeat_per  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request capture and level shaping
    logic [DW-1:0]     r_dt;
    logic              r_down;
    logic              r_need_div;
    logic [LW-1:0]     r_lvl;
    logic [LW-1:0]     r_rem;
    logic [LW-1:0]     r_divisor;
    logic [CNT_W-1:0]  r_cnt;

    logic [LW:0]       rem_shift;
    logic              rem_ge;
    logic [2*LW-1:0]   sq_prod;

    assign rem_shift = {r_rem, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, r_divisor};
    assign sq_prod   = {{LW{1'b0}}, r_lvl} * {{LW{1'b0}}, r_lvl};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dt       <= i_delta_time;
            r_down     <= i_sample > r_thr;
            r_need_div <= 1'b0;
            r_cnt      <= '0;
            r_rem      <= i_sample - r_dlow;
            r_divisor  <= r_dhigh - r_dlow;
            if (r_norm_on) begin
                if (i_sample >= r_dhigh) begin
                    r_lvl <= ONE_VAL;
                end else if (i_sample < r_dlow) begin
                    r_lvl <= '0;
                end else begin
                    r_lvl      <= '0;
                    r_need_div <= 1'b1;
                end
            end else begin
                r_lvl <= (i_sample > ONE_VAL) ? ONE_VAL : i_sample;
            end
        end else if (i_cmd.div_step && r_need_div) begin
            r_cnt <= r_cnt + CNT_W'(1);
            r_rem <= rem_ge ? LW'(rem_shift - {1'b0, r_divisor}) : rem_shift[LW-1:0];
            r_lvl <= {r_lvl[LW-2:0], rem_ge};
        end else if (i_cmd.square && r_square_on) begin
            r_lvl <= LW'(sq_prod >> VALUE_FRAC_BITS);
        end
    end

    // press and repeat state
    logic                  r_was_down;
    logic                  r_pulse_active;
    logic signed [RW-1:0]  r_repeat_count;
    logic [TIME_BITS-1:0]  r_held;
    logic [TIME_BITS-1:0]  r_press_age;
    logic [TIME_BITS-1:0]  r_release_age;

    logic                  n_was_down;
    logic                  n_pulse_active;
    logic signed [RW-1:0]  n_repeat_count;
    logic [TIME_BITS-1:0]  n_held;
    logic [TIME_BITS-1:0]  n_press_age;
    logic [TIME_BITS-1:0]  n_release_age;
    logic                  n_pressed;
    logic                  n_press_edge;
    logic                  n_release_edge;
    logic signed [RW-1:0]  rc_dec;

    assign rc_dec = r_repeat_count - $signed({{(RW-DW){1'b0}}, r_dt});

    always_comb begin
        n_was_down     = r_was_down;
        n_pulse_active = r_pulse_active;
        n_repeat_count = r_repeat_count;
        n_held         = r_held;
        n_press_age    = sat_add(r_press_age, r_dt);
        n_release_age  = sat_add(r_release_age, r_dt);
        n_pressed      = r_down;
        n_press_edge   = 1'b0;
        n_release_edge = 1'b0;
        if (!r_repeat_on) begin
            if (r_was_down && !r_down) begin
                n_release_edge = 1'b1;
                n_release_age  = '0;
            end
            if (!r_was_down && r_down) begin
                n_press_edge = 1'b1;
                n_press_age  = '0;
            end
            n_held     = r_down ? sat_add(r_held, r_dt) : '0;
            n_was_down = r_down;
        end else if (r_down) begin
            if (r_was_down) begin
                if (rc_dec < 0) begin
                    n_press_age    = '0;
                    n_repeat_count = $signed({{(RW-abqr_pkg::DELAY_W){1'b0}}, r_repeat_per});
                    n_pulse_active = 1'b1;
                end else begin
                    n_repeat_count = rc_dec;
                    if (r_pulse_active) begin
                        n_pulse_active = 1'b0;
                        n_release_age  = '0;
                    end
                    n_pressed = 1'b0;
                end
            end else begin
                n_repeat_count = $signed({{(RW-abqr_pkg::DELAY_W){1'b0}}, r_first_delay});
                n_press_age    = '0;
                n_pulse_active = 1'b1;
            end
            n_was_down = 1'b1;
        end else begin
            n_repeat_count = '0;
            n_pulse_active = 1'b0;
            n_press_age    = '0;
            n_was_down     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_down     <= 1'b0;
            r_pulse_active <= 1'b0;
            r_repeat_count <= '0;
            r_held         <= '0;
            r_press_age    <= '0;
            r_release_age  <= '0;
        end else if (i_cmd.finish) begin
            r_was_down     <= n_was_down;
            r_pulse_active <= n_pulse_active;
            r_repeat_count <= n_repeat_count;
            r_held         <= n_held;
            r_press_age    <= n_press_age;
            r_release_age  <= n_release_age;
        end
    end

    // output register
    logic r_out_valid;

    assign o_status = '{
        div_last: !r_need_div || (r_cnt == CNT_W'(VALUE_FRAC_BITS - 1)),
        out_free: !r_out_valid || !i_out_stall
    };
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_pressed       <= n_pressed;
            o_press_edge    <= n_press_edge;
            o_release_edge  <= n_release_edge;
            o_level         <= r_lvl;
            o_hold_time     <= n_held;
            o_since_press   <= n_press_age;
            o_since_release <= n_release_age;
        end
    end

endmodule

### sv/analog_button_qualifier_repeat_top.sv
// top level of the analog button qualifier with auto repeat
// instantiates abqr_ctrl and abqr_datapath, types from abqr_pkg
//
//  channel   handshake                  payload
//  input     i_in_valid / o_in_stall    i_sample, i_delta_time
//  result    o_out_valid / i_out_stall  o_pressed .. o_since_release
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a request inside the dead zone passes through load, the restoring divider that retires
// one quotient bit per cycle, the square step and the final write of the output register;
// any other request skips the divider steps and goes on to the square step and the write
// a new request is taken the cycle after the result is written to the output register
// a result held by i_out_stall keeps the block in its final step, input stalled
// synchronous active-low reset, config is always ready
module analog_button_qualifier_repeat_top #(
    parameter int VALUE_FRAC_BITS = abqr_pkg::VALUE_FRAC_BITS_DEF,
    parameter int TIME_BITS       = abqr_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [abqr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [abqr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [VALUE_FRAC_BITS:0]          i_sample,
    input  logic [abqr_pkg::DELTA_W-1:0]      i_delta_time,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_pressed,
    output logic                              o_press_edge,
    output logic                              o_release_edge,
    output logic [VALUE_FRAC_BITS:0]          o_level,
    output logic [TIME_BITS-1:0]              o_hold_time,
    output logic [TIME_BITS-1:0]              o_since_press,
    output logic [TIME_BITS-1:0]              o_since_release
);

    abqr_pkg::t_cmd    cmd;
    abqr_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    abqr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    abqr_datapath #(
        .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
        .TIME_BITS       (TIME_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_sample        (i_sample),
        .i_delta_time    (i_delta_time),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_pressed       (o_pressed),
        .o_press_edge    (o_press_edge),
        .o_release_edge  (o_release_edge),
        .o_level         (o_level),
        .o_hold_time     (o_hold_time),
        .o_since_press   (o_since_press),
        .o_since_release (o_since_release)
    );

endmodule

### sv/abqr_checker.sv
// port-level checks for analog_button_qualifier_repeat_top, bound to the top level
// depends on abqr_pkg for default widths
module abqr_checker #(
    parameter int VALUE_FRAC_BITS = abqr_pkg::VALUE_FRAC_BITS_DEF,
    parameter int TIME_BITS       = abqr_pkg::TIME_BITS_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_pressed,
    input logic                      o_press_edge,
    input logic                      o_release_edge,
    input logic [VALUE_FRAC_BITS:0]  o_level,
    input logic [TIME_BITS-1:0]      o_since_press,
    input logic [TIME_BITS-1:0]      o_since_release
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_level))
        else $error("result changed while stalled");

    // busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // press edge means pressed and press age restarted
    a_press_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_press_edge |-> o_pressed && o_since_press == '0)
        else $error("press edge inconsistent");

    // release edge means released and release age restarted
    a_release_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_release_edge |-> !o_pressed && !o_press_edge && o_since_release == '0)
        else $error("release edge inconsistent");

endmodule

bind analog_button_qualifier_repeat_top abqr_checker #(
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS),
    .TIME_BITS       (TIME_BITS)
) u_abqr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_pressed       (o_pressed),
    .o_press_edge    (o_press_edge),
    .o_release_edge  (o_release_edge),
    .o_level         (o_level),
    .o_since_press   (o_since_press),
    .o_since_release (o_since_release)
);

### test/button_frame_checker.sv
// checker for the analog button qualifier: predicts each frame result from the
// accepted requests and register writes, compares field by field, counts mismatches
// depends on abqr_pkg
module button_frame_checker
    import abqr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [VALUE_FRAC_BITS_DEF:0] i_sample,
    input  logic [DELTA_W-1:0]         i_delta_time,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_pressed,
    input  logic                       i_press_edge,
    input  logic                       i_release_edge,
    input  logic [VALUE_FRAC_BITS_DEF:0] i_level,
    input  logic [TIME_BITS_DEF-1:0]   i_hold_time,
    input  logic [TIME_BITS_DEF-1:0]   i_since_press,
    input  logic [TIME_BITS_DEF-1:0]   i_since_release,
    output int                         o_pending,
    output int                         o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VF = VALUE_FRAC_BITS_DEF;
    localparam int TW = TIME_BITS_DEF;
    localparam int FULL_SCALE = 1 << VF;

    typedef struct packed {
        logic          pressed;
        logic          press_edge;
        logic          release_edge;
        logic [VF:0]   level;
        logic [TW-1:0] hold_time;
        logic [TW-1:0] since_press;
        logic [TW-1:0] since_release;
    } t_frame_result;

    t_frame_result expected_frames[$];

    logic [VF:0]         thr_q;
    logic [VF:0]         dlo_q;
    logic [VF:0]         dhi_q;
    logic                norm_q;
    logic                sq_q;
    logic                rep_q;
    logic [DELAY_W-1:0]  first_q;
    logic [DELAY_W-1:0]  period_q;

    logic                btn_down_q;
    logic                pulse_on_q;
    logic signed [RC_W-1:0] repeat_left_us;
    logic [TW-1:0]       held_time_us;
    logic [TW-1:0]       age_since_press;
    logic [TW-1:0]       age_since_release;

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        o_errors++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    function automatic logic [TW-1:0] add_sat_us(logic [TW-1:0] a, logic [DELTA_W-1:0] b);
        logic [TW:0] t;
        t = {1'b0, a} + (TW+1)'(b);
        return t[TW] ? {TW{1'b1}} : t[TW-1:0];
    endfunction

    function automatic logic [VF:0] dead_zone_level(logic [VF:0] s);
        int unsigned v;
        if (norm_q) begin
            if (s >= dhi_q) begin
                v = FULL_SCALE;
            end else if (s < dlo_q) begin
                v = 0;
            end else begin
                v = ((int'(s) - int'(dlo_q)) << VF) / (int'(dhi_q) - int'(dlo_q));
            end
        end else begin
            v = (s > FULL_SCALE) ? FULL_SCALE : s;
        end
        if (sq_q) begin
            v = (v * v) >> VF;
        end
        return v[VF:0];
    endfunction

    function automatic t_frame_result qualify_frame(logic [VF:0] s, logic [DELTA_W-1:0] dt);
        t_frame_result r;
        logic down;
        r = '0;
        down = s > thr_q;
        r.level = dead_zone_level(s);
        age_since_press = add_sat_us(age_since_press, dt);
        age_since_release = add_sat_us(age_since_release, dt);
        if (!rep_q) begin
            if (btn_down_q && !down) begin
                r.release_edge = 1'b1;
                age_since_release = '0;
            end
            if (!btn_down_q && down) begin
                r.press_edge = 1'b1;
                age_since_press = '0;
            end
            held_time_us = down ? add_sat_us(held_time_us, dt) : '0;
            btn_down_q = down;
        end else if (down) begin
            if (btn_down_q) begin
                repeat_left_us = repeat_left_us - $signed({{(RC_W-DELTA_W){1'b0}}, dt});
                if (repeat_left_us < 0) begin
                    age_since_press = '0;
                    repeat_left_us = $signed({2'b00, period_q});
                    pulse_on_q = 1'b1;
                end else begin
                    if (pulse_on_q) begin
                        pulse_on_q = 1'b0;
                        age_since_release = '0;
                    end
                    down = 1'b0;
                end
            end else begin
                repeat_left_us = $signed({2'b00, first_q});
                age_since_press = '0;
                pulse_on_q = 1'b1;
            end
            btn_down_q = 1'b1;
        end else begin
            repeat_left_us = '0;
            pulse_on_q = 1'b0;
            age_since_press = '0;
            btn_down_q = 1'b0;
        end
        r.pressed = down;
        r.hold_time = held_time_us;
        r.since_press = age_since_press;
        r.since_release = age_since_release;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            thr_q = (VF+1)'(RST_PRESS_THR_Q12);
            dlo_q = (VF+1)'(RST_DEAD_LOW_Q12);
            dhi_q = (VF+1)'(RST_DEAD_HIGH_Q12);
            norm_q = RST_NORMALIZE_ON;
            sq_q = RST_SQUARE_ON;
            rep_q = RST_REPEAT_ON;
            first_q = RST_FIRST_DELAY;
            period_q = RST_REPEAT_PER;
            btn_down_q = 1'b0;
            pulse_on_q = 1'b0;
            repeat_left_us = '0;
            held_time_us = '0;
            age_since_press = '0;
            age_since_release = '0;
            expected_frames.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PRESS_THRESHOLD:  thr_q = i_cfg_data[VF:0];
                    CFG_DEAD_LOW:         dlo_q = i_cfg_data[VF:0];
                    CFG_DEAD_HIGH:        dhi_q = i_cfg_data[VF:0];
                    CFG_NORMALIZE_ON:     norm_q = i_cfg_data[0];
                    CFG_SQUARE_CURVE_ON:  sq_q = i_cfg_data[0];
                    CFG_REPEAT_ON:        rep_q = i_cfg_data[0];
                    CFG_FIRST_DELAY_US:   first_q = i_cfg_data[DELAY_W-1:0];
                    CFG_REPEAT_PERIOD_US: period_q = i_cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_frames.pop_front();
                    check_field("pressed", i_pressed, want.pressed);
                    check_field("press_edge", i_press_edge, want.press_edge);
                    check_field("release_edge", i_release_edge, want.release_edge);
                    check_field("level", i_level, want.level);
                    check_field("hold_time", i_hold_time, want.hold_time);
                    check_field("since_press", i_since_press, want.since_press);
                    check_field("since_release", i_since_release, want.since_release);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_frames.push_back(qualify_frame(i_sample, i_delta_time));
            end
        end
        o_pending <= expected_frames.size();
    end

endmodule

### test/testbench.sv
// top of the analog button qualifier testbench: clock, reset, register writes,
// frame requests with random gaps and result stalls, watchdog and verdict
// depends on abqr_pkg, analog_button_qualifier_repeat_top and button_frame_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import abqr_pkg::*;

    localparam int VF = VALUE_FRAC_BITS_DEF;
    localparam int TW = TIME_BITS_DEF;
    localparam int FULL_SCALE = 1 << VF;
    localparam int DELTA_MAX = (1 << DELTA_W) - 1;
    localparam int DELAY_MAX = (1 << DELAY_W) - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [VF:0]           i_sample = '0;
    logic [DELTA_W-1:0]    i_delta_time = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_pressed;
    logic                  o_press_edge;
    logic                  o_release_edge;
    logic [VF:0]           o_level;
    logic [TW-1:0]         o_hold_time;
    logic [TW-1:0]         o_since_press;
    logic [TW-1:0]         o_since_release;

    int   pending_frames;
    int   mismatches;
    int   idle_cycles = 0;
    logic calm = 1'b0;
    int   cur_thr = RST_PRESS_THR_Q12;
    int   cur_dlo = RST_DEAD_LOW_Q12;
    int   cur_dhi = RST_DEAD_HIGH_Q12;

    analog_button_qualifier_repeat_top #(
        .VALUE_FRAC_BITS(VF),
        .TIME_BITS(TW)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sample(i_sample),
        .i_delta_time(i_delta_time),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_pressed(o_pressed),
        .o_press_edge(o_press_edge),
        .o_release_edge(o_release_edge),
        .o_level(o_level),
        .o_hold_time(o_hold_time),
        .o_since_press(o_since_press),
        .o_since_release(o_since_release)
    );

    button_frame_checker u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall),
        .i_sample(i_sample),
        .i_delta_time(i_delta_time),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_pressed(o_pressed),
        .i_press_edge(o_press_edge),
        .i_release_edge(o_release_edge),
        .i_level(o_level),
        .i_hold_time(o_hold_time),
        .i_since_press(o_since_press),
        .i_since_release(o_since_release),
        .o_pending(pending_frames),
        .o_errors(mismatches)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 37);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic stop_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic send_frame(int s, int dt);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(30, 1)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= s[VF:0];
        i_delta_time <= dt[DELTA_W-1:0];
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(t_cfg_idx idx, int val);
        wait (pending_frames == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PRESS_THRESHOLD: cur_thr = val;
            CFG_DEAD_LOW:        cur_dlo = val;
            CFG_DEAD_HIGH:       cur_dhi = val;
            default: ;
        endcase
    endtask

    function automatic int pick_sample(logic want_down, logic noisy);
        int s;
        if (noisy) begin
            case ($urandom_range(7))
                0: s = 0;
                1: s = FULL_SCALE;
                2: s = cur_dlo;
                3: s = cur_dhi;
                4: s = (cur_dhi > 0) ? cur_dhi - 1 : 0;
                5: s = cur_thr;
                6: s = (cur_thr < FULL_SCALE) ? cur_thr + 1 : FULL_SCALE;
                default: s = $urandom_range(FULL_SCALE);
            endcase
        end else if (want_down && cur_thr < FULL_SCALE) begin
            s = $urandom_range(FULL_SCALE, cur_thr + 1);
        end else if (!want_down) begin
            s = $urandom_range(cur_thr, 0);
        end else begin
            s = $urandom_range(FULL_SCALE);
        end
        return s;
    endfunction

    function automatic int pick_delta();
        case ($urandom_range(9))
            0: return 0;
            1: return DELTA_MAX;
            2: return $urandom_range(2000);
            default: return $urandom_range(DELTA_MAX);
        endcase
    endfunction

    // runs of held and released frames, with some noise frames mixed in
    task automatic run_random(int n);
        int   run_left;
        logic hold_btn;
        run_left = 0;
        hold_btn = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (run_left == 0) begin
                hold_btn = 1'($urandom_range(1));
                run_left = $urandom_range(16, 1);
            end
            run_left--;
            send_frame(pick_sample(hold_btn, $urandom_range(99) < 15), pick_delta());
            if ($urandom_range(199) == 0) begin
                stop_input();
                wait (pending_frames == 0);
            end
        end
        stop_input();
    endtask

    task automatic hold_button(int n);
        for (int i = 0; i < n; i++) begin
            send_frame(FULL_SCALE, $urandom_range(DELTA_MAX));
        end
        stop_input();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // edges, threshold boundary, dead zone corners, delta extremes
        send_frame(0, 0);
        send_frame(FULL_SCALE, DELTA_MAX);
        send_frame(FULL_SCALE, DELTA_MAX);
        send_frame(2048, 100);
        send_frame(2049, 1);
        send_frame(818, 50);
        send_frame(819, 50);
        send_frame(3685, 50);
        send_frame(3686, 50);
        send_frame(4095, DELTA_MAX);
        send_frame(2049, 0);
        send_frame(2050, 0);
        send_frame(0, DELTA_MAX);
        stop_input();
        run_random(250);

        // raw level, squared, everything above zero pressed, no idling
        calm = 1'b1;
        write_reg(CFG_NORMALIZE_ON, 0);
        write_reg(CFG_SQUARE_CURVE_ON, 1);
        write_reg(CFG_PRESS_THRESHOLD, 0);
        run_random(150);
        calm = 1'b0;

        write_reg(CFG_NORMALIZE_ON, 1);
        write_reg(CFG_DEAD_LOW, 0);
        write_reg(CFG_DEAD_HIGH, FULL_SCALE);
        write_reg(CFG_PRESS_THRESHOLD, FULL_SCALE);
        run_random(100);

        // inverted and empty dead zone
        write_reg(CFG_SQUARE_CURVE_ON, 0);
        write_reg(CFG_DEAD_LOW, 3000);
        write_reg(CFG_DEAD_HIGH, 1000);
        write_reg(CFG_PRESS_THRESHOLD, 1000);
        run_random(100);
        write_reg(CFG_DEAD_LOW, 2000);
        write_reg(CFG_DEAD_HIGH, 2000);
        run_random(60);
        hold_button(3);

        // auto repeat, entered while held
        write_reg(CFG_REPEAT_ON, 1);
        write_reg(CFG_PRESS_THRESHOLD, RST_PRESS_THR_Q12);
        write_reg(CFG_DEAD_LOW, RST_DEAD_LOW_Q12);
        write_reg(CFG_DEAD_HIGH, RST_DEAD_HIGH_Q12);
        write_reg(CFG_FIRST_DELAY_US, 100000);
        write_reg(CFG_REPEAT_PERIOD_US, 30000);
        run_random(250);
        write_reg(CFG_FIRST_DELAY_US, 0);
        write_reg(CFG_REPEAT_PERIOD_US, 0);
        run_random(150);
        write_reg(CFG_FIRST_DELAY_US, DELAY_MAX);
        write_reg(CFG_REPEAT_PERIOD_US, DELAY_MAX);
        run_random(60);
        write_reg(CFG_FIRST_DELAY_US, 200000);
        write_reg(CFG_REPEAT_PERIOD_US, 0);
        run_random(60);
        hold_button(3);

        // back to edge mode while held
        write_reg(CFG_REPEAT_ON, 0);
        write_reg(CFG_PRESS_THRESHOLD, 2047);
        write_reg(CFG_DEAD_LOW, FULL_SCALE);
        write_reg(CFG_DEAD_HIGH, 0);
        run_random(100);
        write_reg(CFG_DEAD_HIGH, FULL_SCALE);
        write_reg(CFG_SQUARE_CURVE_ON, 1);
        run_random(50);

        wait (pending_frames == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
